// File: hw/rtl/ctl_pkg.sv
// ctl_pkg: shared types, constants, keyword table and helper functions
// for the c token lexer.
// No dependencies; every other file of the block uses it.
package ctl_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 8;
    localparam int KIND_W   = 4;
    localparam int KW_IDX_W = 5;

    // keyword table shape and parameter defaults
    localparam int KW_MAX_LEN        = 8;
    localparam int KW_SLOTS          = 32;
    localparam int KEYWORD_BYTES_DEF = 8;
    localparam int KEYWORD_COUNT_DEF = 24;

    // result queue depth (must hold two results beyond the one on show)
    localparam int FIFO_DEPTH = 4;

    // character codes
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_PCT    = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_D      = 8'h64;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;

    // token kinds
    typedef enum logic [KIND_W-1:0] {
        TK_KEYWORD  = 4'd0,
        TK_IDENT    = 4'd1,
        TK_NUMBER   = 4'd2,
        TK_RELOP    = 4'd3,
        TK_OP       = 4'd4,
        TK_DELIM    = 4'd5,
        TK_FMTSPEC  = 4'd6,
        TK_UNKNOWN  = 4'd7,
        TK_INVALID  = 4'd8,
        TK_UNCLOSED = 4'd9
    } t_kind;

    // one result record
    typedef struct packed {
        t_kind               kind;
        logic [LEN_W-1:0]    length;
        logic [KW_IDX_W-1:0] kw_index;
        logic [BYTE_W-1:0]   first_char;
        logic [BYTE_W-1:0]   second_char;
        logic                last;
    } t_rec;

    // up to two results handed from the lexer step to the result queue
    typedef struct packed {
        logic [1:0] n;
        t_rec       rec0;
        logic       rec1_unused_pad;
        t_rec       rec1;
    } t_push;

    // keyword text, right aligned: last character in the low byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_SLOTS] = '{
        64'("int"),      64'("while"),    64'("break"),    64'("for"),
        64'("do"),       64'("if"),       64'("float"),    64'("char"),
        64'("switch"),   64'("double"),   64'("short"),    64'("long"),
        64'("unsigned"), 64'("sizeof"),   64'("else"),     64'("register"),
        64'("extern"),   64'("static"),   64'("auto"),     64'("case"),
        64'("break"),    64'("volatile"), 64'("enum"),     64'("typedef"),
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
    };

    localparam logic [3:0] KW_LEN [KW_SLOTS] = '{
        4'd3, 4'd5, 4'd5, 4'd3, 4'd2, 4'd2, 4'd5, 4'd4,
        4'd6, 4'd6, 4'd5, 4'd4, 4'd8, 4'd6, 4'd4, 4'd8,
        4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd8, 4'd4, 4'd7,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    // ascii letter
    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // ascii digit
    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // build a result record, not yet marked last
    function automatic t_rec make_rec(input t_kind               kind,
                                      input logic [LEN_W-1:0]    length,
                                      input logic [KW_IDX_W-1:0] kw_index,
                                      input logic [BYTE_W-1:0]   c1,
                                      input logic [BYTE_W-1:0]   c2);
        t_rec r;
        r.kind        = kind;
        r.length      = length;
        r.kw_index    = kw_index;
        r.first_char  = c1;
        r.second_char = c2;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// File: hw/rtl/ctl_byte_if.sv
// ctl_byte_if: source byte channel of the lexer (valid/ready handshake).
// Depends on ctl_pkg for the byte width.
interface ctl_byte_if;
    logic                       valid;
    logic                       ready;
    logic [ctl_pkg::BYTE_W-1:0] ch;
    logic                       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

// File: hw/rtl/ctl_token_if.sv
// ctl_token_if: token result channel of the lexer (valid/ready handshake).
// Depends on ctl_pkg for the field widths.
interface ctl_token_if;
    logic                         valid;
    logic                         ready;
    logic [ctl_pkg::KIND_W-1:0]   token_kind;
    logic [ctl_pkg::LEN_W-1:0]    token_length;
    logic [ctl_pkg::KW_IDX_W-1:0] keyword_index;
    logic [ctl_pkg::BYTE_W-1:0]   first_char;
    logic [ctl_pkg::BYTE_W-1:0]   second_char;
    logic                         last_result;

    modport source (output valid, output token_kind, output token_length,
                    output keyword_index, output first_char, output second_char,
                    output last_result, input ready);
    modport sink   (input valid, input token_kind, input token_length,
                    input keyword_index, input first_char, input second_char,
                    input last_result, output ready);
endinterface

// File: hw/rtl/ctl_kw_match.sv
// ctl_kw_match: parallel compare of the stored word prefix against the
// keyword table, first matching entry wins. Depends on ctl_pkg.
module ctl_kw_match #(
    parameter int KEYWORD_BYTES = ctl_pkg::KEYWORD_BYTES_DEF,
    parameter int KEYWORD_COUNT = ctl_pkg::KEYWORD_COUNT_DEF
) (
    input  logic [ctl_pkg::BYTE_W-1:0]   i_prefix [KEYWORD_BYTES],
    input  logic [ctl_pkg::LEN_W-1:0]    i_count,
    output logic                         o_hit,
    output logic [ctl_pkg::KW_IDX_W-1:0] o_index
);

    logic [ctl_pkg::KW_MAX_LEN-1:0] eq [KEYWORD_COUNT];
    logic [KEYWORD_COUNT-1:0]       hit;

    // per entry: length equal and every stored character equal
    for (genvar gi = 0; gi < KEYWORD_COUNT; gi++) begin : g_entry
        localparam int L = int'(ctl_pkg::KW_LEN[gi]);
        for (genvar gj = 0; gj < ctl_pkg::KW_MAX_LEN; gj++) begin : g_char
            if (gj < L) begin : g_cmp
                assign eq[gi][gj] =
                    (i_prefix[gj] == ctl_pkg::KW_TEXT[gi][8*(L-1-gj) +: 8]);
            end else begin : g_pad
                assign eq[gi][gj] = 1'b1;
            end
        end
        assign hit[gi] = (L != 0) && (i_count == ctl_pkg::LEN_W'(L)) && (&eq[gi]);
    end

    // priority pick, lowest index wins
    always_comb begin
        o_index = '0;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_index = ctl_pkg::KW_IDX_W'(i);
            end
        end
    end

    assign o_hit = |hit;

endmodule

// File: hw/rtl/ctl_step.sv
// ctl_step: input register, lexer state and one-pass next-state and
// result logic for one source byte. Depends on ctl_pkg, ctl_byte_if,
// ctl_kw_match.
module ctl_step #(
    parameter int KEYWORD_BYTES = ctl_pkg::KEYWORD_BYTES_DEF,
    parameter int KEYWORD_COUNT = ctl_pkg::KEYWORD_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ctl_byte_if.sink       i_src,
    input  logic           i_room,
    output ctl_pkg::t_push o_push
);

    localparam int PIDX_W = (KEYWORD_BYTES > 1) ? $clog2(KEYWORD_BYTES) : 1;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_WORD    = 8'b0000_0010,
        M_NUM     = 8'b0000_0100,
        M_REL     = 8'b0000_1000,
        M_SLASH   = 8'b0001_0000,
        M_CMT     = 8'b0010_0000,
        M_CMTSTAR = 8'b0100_0000,
        M_SPEC    = 8'b1000_0000
    } t_mode;

    t_mode                         r_mode, n_mode;
    logic [ctl_pkg::LEN_W-1:0]     r_count, n_count;
    logic [ctl_pkg::BYTE_W-1:0]    r_pend, n_pend;
    logic [ctl_pkg::BYTE_W-1:0]    r_prefix [KEYWORD_BYTES];
    logic                          r_in_valid;
    logic [ctl_pkg::BYTE_W-1:0]    r_ch;
    logic                          r_eoi;

    logic                          go;
    logic                          kw_hit;
    logic [ctl_pkg::KW_IDX_W-1:0]  kw_idx;
    logic [ctl_pkg::LEN_W-1:0]     cnt_inc;
    logic                          alnum;

    // idle decode of the current byte
    t_mode                         id_mode;
    logic [ctl_pkg::LEN_W-1:0]     id_count;
    logic                          id_pend_we;
    logic                          id_emit;
    ctl_pkg::t_kind                id_kind;
    ctl_pkg::t_rec                 id_rec;

    // step outcome
    logic                          use_idle;
    logic                          emit_a;
    ctl_pkg::t_rec                 rec_a;
    logic                          pre_we;
    logic [PIDX_W-1:0]             pre_idx;

    // input register, refilled in the cycle it empties
    assign go          = r_in_valid & i_room;
    assign i_src.ready = ~r_in_valid | go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src.valid && i_src.ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_ch  <= i_src.ch;
            r_eoi <= i_src.end_of_input;
        end
    end

    // keyword lookup on the stored prefix
    ctl_kw_match #(
        .KEYWORD_BYTES (KEYWORD_BYTES),
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_kw (
        .i_prefix (r_prefix),
        .i_count  (r_count),
        .o_hit    (kw_hit),
        .o_index  (kw_idx)
    );

    assign cnt_inc = (r_count == {ctl_pkg::LEN_W{1'b1}}) ? r_count : r_count + 1'b1;
    assign alnum   = ctl_pkg::is_letter(r_ch) | ctl_pkg::is_digit(r_ch);

    // what the byte starts when seen from idle
    always_comb begin
        id_mode    = M_IDLE;
        id_count   = '0;
        id_pend_we = 1'b0;
        id_emit    = 1'b0;
        id_kind    = ctl_pkg::TK_UNKNOWN;
        if (ctl_pkg::is_letter(r_ch)) begin
            id_mode  = M_WORD;
            id_count = ctl_pkg::LEN_W'(1);
        end else if (ctl_pkg::is_digit(r_ch)) begin
            id_mode  = M_NUM;
            id_count = ctl_pkg::LEN_W'(1);
        end else if (r_ch == ctl_pkg::CH_BANG || r_ch == ctl_pkg::CH_EQ ||
                     r_ch == ctl_pkg::CH_LT || r_ch == ctl_pkg::CH_GT) begin
            id_mode    = M_REL;
            id_count   = ctl_pkg::LEN_W'(1);
            id_pend_we = 1'b1;
        end else if (r_ch == ctl_pkg::CH_SLASH) begin
            id_mode = M_SLASH;
        end else if (r_ch == ctl_pkg::CH_SPACE || r_ch == ctl_pkg::CH_TAB ||
                     r_ch == ctl_pkg::CH_LF) begin
            id_mode = M_IDLE;
        end else if (r_ch == ctl_pkg::CH_LPAREN || r_ch == ctl_pkg::CH_RPAREN ||
                     r_ch == ctl_pkg::CH_COMMA || r_ch == ctl_pkg::CH_LBRACE ||
                     r_ch == ctl_pkg::CH_RBRACE || r_ch == ctl_pkg::CH_SEMI ||
                     r_ch == ctl_pkg::CH_QUOTE) begin
            id_emit = 1'b1;
            id_kind = ctl_pkg::TK_DELIM;
        end else if (r_ch == ctl_pkg::CH_PCT || r_ch == ctl_pkg::CH_PLUS ||
                     r_ch == ctl_pkg::CH_MINUS || r_ch == ctl_pkg::CH_STAR ||
                     r_ch == ctl_pkg::CH_AMP) begin
            id_mode    = M_SPEC;
            id_count   = ctl_pkg::LEN_W'(1);
            id_pend_we = 1'b1;
        end else begin
            id_emit = 1'b1;
        end
        id_rec = ctl_pkg::make_rec(id_kind, ctl_pkg::LEN_W'(1), '0, r_ch, '0);
    end

    // lexer step
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_pend   = r_pend;
        use_idle = 1'b0;
        emit_a   = 1'b0;
        rec_a    = ctl_pkg::make_rec(ctl_pkg::TK_UNCLOSED, '0, '0, '0, '0);
        pre_we   = 1'b0;
        pre_idx  = r_count[PIDX_W-1:0];

        if (r_eoi) begin
            // end of source: only an open comment is reported
            emit_a  = (r_mode == M_CMT) || (r_mode == M_CMTSTAR);
            n_mode  = M_IDLE;
            n_count = '0;
            n_pend  = '0;
        end else begin
            unique case (r_mode)
                M_WORD: begin
                    if (alnum) begin
                        pre_we  = (r_count < ctl_pkg::LEN_W'(KEYWORD_BYTES));
                        n_count = cnt_inc;
                    end else begin
                        emit_a   = 1'b1;
                        rec_a    = kw_hit ?
                            ctl_pkg::make_rec(ctl_pkg::TK_KEYWORD, r_count, kw_idx, '0, '0) :
                            ctl_pkg::make_rec(ctl_pkg::TK_IDENT, r_count, '0, '0, '0);
                        use_idle = 1'b1;
                    end
                end
                M_NUM: begin
                    if (ctl_pkg::is_digit(r_ch) || r_ch == ctl_pkg::CH_DOT) begin
                        n_count = cnt_inc;
                    end else begin
                        emit_a   = 1'b1;
                        rec_a    = ctl_pkg::make_rec(ctl_pkg::TK_NUMBER, r_count, '0, '0, '0);
                        use_idle = 1'b1;
                    end
                end
                M_REL: begin
                    emit_a = 1'b1;
                    if (r_ch == ctl_pkg::CH_EQ) begin
                        rec_a   = ctl_pkg::make_rec(ctl_pkg::TK_RELOP, ctl_pkg::LEN_W'(2),
                                                    '0, r_pend, r_ch);
                        n_mode  = M_IDLE;
                        n_count = '0;
                    end else begin
                        rec_a    = ctl_pkg::make_rec(ctl_pkg::TK_OP, ctl_pkg::LEN_W'(1),
                                                     '0, r_pend, '0);
                        use_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (r_ch == ctl_pkg::CH_STAR) begin
                        n_mode = M_CMT;
                    end else begin
                        emit_a   = 1'b1;
                        rec_a    = ctl_pkg::make_rec(ctl_pkg::TK_INVALID, ctl_pkg::LEN_W'(1),
                                                     '0, ctl_pkg::CH_SLASH, '0);
                        use_idle = 1'b1;
                    end
                end
                M_CMT: begin
                    if (r_ch == ctl_pkg::CH_STAR) begin
                        n_mode = M_CMTSTAR;
                    end
                end
                M_CMTSTAR: begin
                    if (r_ch == ctl_pkg::CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (r_ch != ctl_pkg::CH_STAR) begin
                        n_mode = M_CMT;
                    end
                end
                M_SPEC: begin
                    emit_a = 1'b1;
                    if (r_ch == ctl_pkg::CH_D || r_ch == ctl_pkg::CH_F) begin
                        rec_a   = ctl_pkg::make_rec(ctl_pkg::TK_FMTSPEC, ctl_pkg::LEN_W'(2),
                                                    '0, r_pend, r_ch);
                        n_mode  = M_IDLE;
                        n_count = '0;
                    end else begin
                        rec_a    = ctl_pkg::make_rec(ctl_pkg::TK_OP, ctl_pkg::LEN_W'(1),
                                                     '0, r_pend, '0);
                        use_idle = 1'b1;
                    end
                end
                M_IDLE: begin
                    use_idle = 1'b1;
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase
        end

        // ending byte looked at again from idle
        if (use_idle) begin
            n_mode  = id_mode;
            n_count = id_count;
            if (id_pend_we) begin
                n_pend = r_ch;
            end
            if (id_mode == M_WORD) begin
                pre_we  = 1'b1;
                pre_idx = '0;
            end
        end
    end

    // results towards the queue
    always_comb begin
        o_push      = '0;
        o_push.rec1 = id_rec;
        o_push.rec1.last = 1'b1;
        if (go) begin
            o_push.n = 2'(emit_a) + 2'(use_idle & id_emit);
        end
        o_push.rec0      = emit_a ? rec_a : id_rec;
        o_push.rec0.last = ~(emit_a & use_idle & id_emit);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_count <= '0;
        end else if (go) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_pend <= n_pend;
            if (pre_we) begin
                r_prefix[pre_idx] <= r_ch;
            end
        end
    end

    // end of source always leaves the lexer idle and cleared
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_eoi) |=> (r_mode == M_IDLE && r_count == '0))
        else $error("lexer not idle after end of source");

    // no token is produced while inside a comment
    a_cmt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !r_eoi && (r_mode == M_CMT || r_mode == M_CMTSTAR)) |-> (o_push.n == 2'd0))
        else $error("token produced inside a comment");

    // state moves only when a byte is consumed
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !go |=> ($stable(r_mode) && $stable(r_count)))
        else $error("lexer state changed without a byte");

endmodule

// File: hw/rtl/ctl_out_fifo.sv
// ctl_out_fifo: small result queue taking up to two results per cycle and
// showing one per beat on the token channel. Depends on ctl_pkg,
// ctl_token_if.
module ctl_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ctl_pkg::t_push i_push,
    output logic           o_room,
    ctl_token_if.source    o_tok
);

    localparam int DEPTH = ctl_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctl_pkg::t_rec      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               pop;
    logic [CNT_W-1:0]   after_pop;
    ctl_pkg::t_rec      head;

    assign pop       = o_tok.valid & o_tok.ready;
    assign after_pop = r_count - CNT_W'(pop);
    assign o_room    = (after_pop <= CNT_W'(DEPTH - 2));

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.n);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= after_pop + CNT_W'(i_push.n);
        end
    end

    // result storage, one or two slots written per cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_push.n != 2'd0 && PTR_W'(k) == r_wr) begin
                r_mem[k] <= i_push.rec0;
            end else if (i_push.n == 2'd2 && PTR_W'(k) == PTR_W'(r_wr + 1'b1)) begin
                r_mem[k] <= i_push.rec1;
            end
        end
    end

    // head of queue on the channel
    assign head                = r_mem[r_rd];
    assign o_tok.valid         = (r_count != '0);
    assign o_tok.token_kind    = head.kind;
    assign o_tok.token_length  = head.length;
    assign o_tok.keyword_index = head.kw_index;
    assign o_tok.first_char    = head.first_char;
    assign o_tok.second_char   = head.second_char;
    assign o_tok.last_result   = head.last;

    // fill level never passes the depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // first of a pair is never the last result of its byte
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n == 2'd2) |-> !i_push.rec0.last)
        else $error("first of two results marked last");

    // a single result is always the last of its byte
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n == 2'd1) |-> i_push.rec0.last)
        else $error("single result not marked last");

endmodule

// File: hw/rtl/c_token_lexer_top.sv
// c_token_lexer_top: top level of the c token lexer.
// Depends on ctl_pkg, ctl_byte_if, ctl_token_if, ctl_step, ctl_out_fifo.
//
// The lexer takes one source byte per clock on i_src while the result queue
// has room, and returns token records on o_tok, one record per beat. A byte
// passes an input register, is lexed combinationally (keyword match is a
// parallel compare) and its zero, one or two tokens are registered into a
// four-entry result queue, whose head drives o_tok. Bytes are taken back to
// back as long as the queue has room for two more records; a byte that ends
// one token and starts another (a delimiter after a word, say) uses two
// output beats, so a steady stream of such bytes is held back by the single
// read port of the result queue. last_result marks the final record of each
// byte; bytes that end no token give no record.
module c_token_lexer_top #(
    parameter int KEYWORD_BYTES = ctl_pkg::KEYWORD_BYTES_DEF,
    parameter int KEYWORD_COUNT = ctl_pkg::KEYWORD_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctl_byte_if.sink    i_src,
    ctl_token_if.source o_tok
);

    ctl_pkg::t_push push;
    logic           room;

    // byte register and lexer state
    ctl_step #(
        .KEYWORD_BYTES (KEYWORD_BYTES),
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_room  (room),
        .o_push  (push)
    );

    // result queue
    ctl_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule
